[src/swm_pkg.sv]
// Shared types and constants for the sliding window maximum block.
package swm_pkg;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int WSIZE_W  = 7;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    // Register word index
    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [POS_W-1:0]           pos_t;
    typedef logic [WSIZE_W-1:0]         wsize_t;

    // One deque entry: sample value and the position it arrived at
    typedef struct packed {
        sample_t value;
        pos_t    pos;
    } entry_t;

endpackage

[src/swm_ram.sv]
// Deque storage: one write port, one registered read port.
module swm_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  swm_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output swm_pkg::entry_t rd_data
);

    swm_pkg::entry_t mem [0:DEPTH-1];
    swm_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data valid the cycle after the address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/sliding_window_maximum.sv]
// Top level: running maximum over the last window_size samples.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+--------------------------------
//  input    | sample_valid / sample_ready  | sample[31:0] signed, restart
//  output   | max_valid / max_ready        | window_max[31:0] signed
//  config   | psel penable pwrite pready   | paddr[2:0] pwdata/prdata[31:0]
//
// A sample is processed by examining B deque entries at the back and F
// entries at the front; each examined entry takes a RAM read and then a
// compare. Each sample is pushed once and popped at most once.
// Reset clears the deque, position counter and window_size (to 1); no
// clearing pass is needed. A pending result that is not taken holds the
// sequencer in its append step; the next sample is taken once it is back idle.
module sliding_window_maximum #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swm_pkg::ADDR_W-1:0]    paddr,
    input  logic [swm_pkg::DATA_W-1:0]    pwdata,
    output logic [swm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // Sample input
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [31:0]            sample,
    input  logic                          restart,
    // Maximum output
    output logic                          max_valid,
    input  logic                          max_ready,
    output logic signed [31:0]            window_max
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = CW + 1;
    localparam int KCAP = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
    localparam logic [swm_pkg::WSIZE_W-1:0] K_CAP = swm_pkg::WSIZE_W'(KCAP);
    localparam logic [CW-1:0] COUNT_MAX = CW'(WINDOW_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BACK_RD,
        S_BACK_CMP,
        S_FRONT_RD,
        S_FRONT_CMP,
        S_APPEND
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    swm_pkg::pos_t            pos_reg, pos_next;
    logic                     filled_reg, filled_next;
    swm_pkg::wsize_t          k_reg, k_next;
    logic                     max_valid_reg, max_valid_next;
    swm_pkg::sample_t         window_max_reg, window_max_next;
    swm_pkg::wsize_t          window_size_reg, window_size_next;
    swm_pkg::sample_t         sample_reg, sample_next;
    swm_pkg::sample_t         front_reg, front_next;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    swm_pkg::entry_t          wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    swm_pkg::entry_t          rd_data;

    swm_pkg::wsize_t          k_eff;
    swm_pkg::pos_t            age;
    logic [swm_pkg::POS_W:0]  pos_inc;
    logic                     fill_now;
    logic                     go;
    logic                     cfg_wr;

    // Ring index of head + offset, wrapping at WINDOW_MAX
    function automatic logic [AW-1:0] ring(input logic [AW-1:0] head,
                                           input logic [CW-1:0] offset);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(offset);
        if (sum >= SW'(WINDOW_MAX))
        begin
            sum = sum - SW'(WINDOW_MAX);
        end
        return sum[AW-1:0];
    endfunction

    swm_ram #(
        .DEPTH (WINDOW_MAX),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[2] == swm_pkg::REG_WINDOW_SIZE);
    assign window_size_next = cfg_wr ? pwdata[swm_pkg::WSIZE_W-1:0] : window_size_reg;
    assign prdata = (paddr[2] == swm_pkg::REG_WINDOW_SIZE) ?
                    swm_pkg::DATA_W'(window_size_reg) : '0;

    // Effective window: zero means 1, capped at the deque depth
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k_eff = swm_pkg::WSIZE_W'(1);
        end
        else if (window_size_reg > K_CAP)
        begin
            k_eff = K_CAP;
        end
        else
        begin
            k_eff = window_size_reg;
        end
    end

    assign age      = pos_reg - rd_data.pos;
    assign pos_inc  = {1'b0, pos_reg} + (swm_pkg::POS_W + 1)'(1);
    assign fill_now = filled_reg || (pos_inc >= (swm_pkg::POS_W + 1)'(k_reg));
    assign go       = !fill_now || !max_valid_reg || max_ready;

    assign sample_ready = (state_reg == S_IDLE);
    assign max_valid    = max_valid_reg;
    assign window_max   = window_max_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        filled_next     = filled_reg;
        k_next          = k_reg;
        sample_next     = sample_reg;
        front_next      = front_reg;
        window_max_next = window_max_reg;
        max_valid_next  = max_valid_reg && !max_ready;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = ring(head_reg, count_reg);
        wr_data.value   = sample_reg;
        wr_data.pos     = pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    sample_next = sample;
                    k_next      = k_eff;
                    if (restart)
                    begin
                        head_next   = '0;
                        count_next  = '0;
                        pos_next    = '0;
                        filled_next = 1'b0;
                    end
                    state_next = S_BACK_RD;
                end
            end
            S_BACK_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ring(head_reg, count_reg - CW'(1));
                    state_next = S_BACK_CMP;
                end
            end
            S_BACK_CMP:
            begin
                // Pop the back entry if it is not greater than the sample
                if (rd_data.value <= sample_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_BACK_RD;
                end
                else
                begin
                    state_next = S_FRONT_RD;
                end
            end
            S_FRONT_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = S_FRONT_CMP;
                end
            end
            S_FRONT_CMP:
            begin
                // Pop the front entry once it has aged out of the window
                if (age >= swm_pkg::POS_W'(k_reg))
                begin
                    head_next  = ring(head_reg, CW'(1));
                    count_next = count_reg - CW'(1);
                    state_next = S_FRONT_RD;
                end
                else
                begin
                    front_next = rd_data.value;
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                // Wait here while a result is still pending on the output and this sample makes a new one
                if (go)
                begin
                    if (count_reg < COUNT_MAX)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    pos_next    = pos_inc[swm_pkg::POS_W-1:0];
                    filled_next = fill_now;
                    if (fill_now)
                    begin
                        max_valid_next  = 1'b1;
                        window_max_next = (count_reg == '0) ? sample_reg : front_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            pos_reg         <= '0;
            filled_reg      <= 1'b0;
            k_reg           <= swm_pkg::WSIZE_W'(1);
            max_valid_reg   <= 1'b0;
            window_max_reg  <= '0;
            window_size_reg <= swm_pkg::WSIZE_W'(1);
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            pos_reg         <= pos_next;
            filled_reg      <= filled_next;
            k_reg           <= k_next;
            max_valid_reg   <= max_valid_next;
            window_max_reg  <= window_max_next;
            window_size_reg <= window_size_next;
        end
    end

    // Payload of the transaction in progress
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        front_reg  <= front_next;
    end

endmodule
